// ===== src/rtd_pkg.sv =====
// ----------------------------------------------------------------------------
// rtd_pkg
// Register indexes, reset values and limits for the RTD averaging core.
// ----------------------------------------------------------------------------
package rtd_pkg;

  typedef enum logic [2:0] {
    REG_SAMPLE_COUNT = 3'd0,
    REG_REF_RES      = 3'd1,
    REG_ZERO_RES     = 3'd2,
    REG_COEF_LIN     = 3'd3,
    REG_COEF_SQ      = 3'd4
  } cfg_reg_t;

  localparam logic [7:0]  RST_SAMPLE_COUNT = 8'd10;
  localparam logic [15:0] RST_REF_RES      = 16'd43000;
  localparam logic [15:0] RST_ZERO_RES     = 16'd10000;
  localparam logic [35:0] RST_COEF_LIN     = 36'd4297221300;
  localparam logic [31:0] RST_COEF_SQ      = 32'hFFF64F28; // -635096

  localparam logic signed [14:0] TEMP_MAX = 15'sd9000;
  localparam logic signed [14:0] TEMP_MIN = -15'sd2500;

  localparam int SUM_W = 23;

endpackage

// ===== src/rtd_smul.sv =====
// ----------------------------------------------------------------------------
// rtd_smul
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module rtd_smul #(
  parameter int AW = 36,
  parameter int BW = 36
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [AW-1:0]        a,
  input  logic [BW-1:0]        b,
  output logic                 busy,
  output logic [AW+BW-1:0]     product
);

  localparam int CW = $clog2(BW + 1);

  logic [AW+BW-1:0] p;
  logic [AW-1:0]    areg;
  logic [CW-1:0]    cnt;
  logic [AW:0]      sum;

  // add the multiplicand when the low bit of the multiplier is set
  assign sum     = {1'b0, p[AW+BW-1:BW]} + (p[0] ? {1'b0, areg} : '0);
  assign product = p;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      p    <= {{AW{1'b0}}, b};
      areg <= a;
      cnt  <= CW'(BW);
      busy <= 1'b1;
    end else if (busy) begin
      p   <= {sum, p[BW-1:1]};
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// ===== src/rtd_sdiv.sv =====
// ----------------------------------------------------------------------------
// rtd_sdiv
// Restoring divider, one quotient bit per cycle. The caller guarantees that
// the quotient fits in QW bits.
// ----------------------------------------------------------------------------
module rtd_sdiv #(
  parameter int NW = 63,
  parameter int DW = 39,
  parameter int QW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic [QW-1:0] quotient
);

  localparam int CW = $clog2(QW + 1);

  logic [DW-1:0] rem;
  logic [DW-1:0] dreg;
  logic [QW-1:0] lowq;
  logic [CW-1:0] cnt;
  logic [DW:0]   t;
  logic [DW:0]   diff;
  logic          ge;

  assign t        = {rem, lowq[QW-1]};
  assign ge       = t >= {1'b0, dreg};
  assign diff     = t - {1'b0, dreg};
  assign quotient = lowq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      rem  <= DW'(num >> QW);
      lowq <= num[QW-1:0];
      dreg <= den;
      cnt  <= CW'(QW);
      busy <= 1'b1;
    end else if (busy) begin
      rem  <= ge ? diff[DW-1:0] : t[DW-1:0];
      lowq <= {lowq[QW-2:0], ge};
      cnt  <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// ===== src/rtd_average_to_temperature_core.sv =====
// ----------------------------------------------------------------------------
// rtd_average_to_temperature_core
// Averages clean RTD codes and converts the mean to tenths of degC with the
// inverse Callendar-Van Dusen quadratic, using bit-serial arithmetic.
// ----------------------------------------------------------------------------
//  channel  handshake              payload
//  item     item_valid/item_stall  raw_word, fault_status
//  result   result_valid/          temp_tenths, temp_updated, fault_code,
//           result_stall           alarm_raised
//  cfg      cfg_valid/cfg_ready    cfg_index, cfg_data
//
// An item that does not convert goes from S_IDLE to S_DONE, which loads the
// result registers when the channel is free. A converting item passes
// through the serial squaring of coefficient A, the ratio divide, the B*d
// product, the root and the final divide, with control states between.
// One item is in work at a time; a stalled result holds its register.
// Reset clears sums, counter, held temperature, alarm, valid; loads config.
// ----------------------------------------------------------------------------
module rtd_average_to_temperature_core
  import rtd_pkg::*;
#(
  parameter int CODE_BITS = 15
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [15:0]        raw_word,
  input  logic [7:0]         fault_status,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [14:0] temp_tenths,
  output logic               temp_updated,
  output logic [7:0]         fault_code,
  output logic               alarm_raised,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [35:0]        cfg_data
);

  localparam int DNM_W = 24 + CODE_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_MULW, S_SAT, S_DIVW, S_RHO, S_PROD, S_PRODW,
    S_DISC, S_SQRT, S_DEN, S_CHK, S_DIV2W, S_FIN, S_DONE
  } state_t;

  state_t state;

  logic [7:0]  sample_count;
  logic [15:0] reference_resistance;
  logic [15:0] zero_resistance;
  logic [35:0] coef_linear;
  logic [31:0] coef_square;

  logic [SUM_W-1:0] sample_sum;
  logic [7:0]       sample_counter;
  logic signed [14:0] held_temperature;
  logic             alarm_latched;

  logic [SUM_W-1:0] conv_sum;
  logic [7:0]       conv_cnt;
  logic             p_upd;
  logic             p_raised;
  logic [7:0]       p_fault;

  logic [32:0] rho;
  logic        dneg;
  logic [31:0] dmag;
  logic [63:0] sq_v;
  logic [31:0] sq_r;
  logic [33:0] sq_rem;
  logic [4:0]  sq_cnt;
  logic [45:0] n2;
  logic [33:0] d2;
  logic signed [14:0] tres;

  logic [CODE_BITS-1:0] code;
  logic                 accept;

  logic        mul_start, prod_start, div1_start, div2_start;
  logic        num_busy, dnm_busy, a2_busy, prod_busy, div1_busy, div2_busy;
  logic [38:0] num_p;
  logic [23:0] dnm_p;
  logic [71:0] a2_p;
  logic [63:0] prod_p;
  logic [31:0] q1;
  logic [13:0] q2;

  logic [DNM_W-1:0] dnm;
  logic [53:0]      a2;
  logic             sat1;
  logic [31:0]      bmag;
  logic             plus;
  logic [35:0]      rem_sh;
  logic [35:0]      trial;
  logic             sq_ge;
  logic [32:0]      den;

  assign code   = CODE_BITS'(raw_word >> 1);
  assign accept = item_valid && !item_stall;

  assign item_stall = (state != S_IDLE);
  assign cfg_ready  = 1'b1;

  assign mul_start  = (state == S_MUL);
  assign prod_start = (state == S_PROD);
  assign div1_start = (state == S_SAT) && !sat1;
  assign div2_start = (state == S_CHK) && ({2'b0, n2} < {d2, 14'b0});

  assign dnm  = {dnm_p, {CODE_BITS{1'b0}}};
  assign a2   = a2_p[71:18];
  assign sat1 = {9'b0, num_p} >= {dnm, 8'b0};
  assign bmag = coef_square[31] ? (~coef_square + 32'd1) : coef_square;
  assign plus = coef_square[31] != dneg;

  assign rem_sh = {sq_rem, sq_v[63:62]};
  assign trial  = {2'b0, sq_r, 2'b01};
  assign sq_ge  = rem_sh >= trial;
  assign den    = 33'(coef_linear >> 9) + {1'b0, sq_r};

  rtd_smul #(.AW(16), .BW(SUM_W)) u_mul_num (
    .clk(clk), .rst(rst), .start(mul_start), .a(reference_resistance),
    .b(conv_sum), .busy(num_busy), .product(num_p)
  );

  rtd_smul #(.AW(16), .BW(8)) u_mul_dnm (
    .clk(clk), .rst(rst), .start(mul_start), .a(zero_resistance),
    .b(conv_cnt), .busy(dnm_busy), .product(dnm_p)
  );

  rtd_smul #(.AW(36), .BW(36)) u_mul_a2 (
    .clk(clk), .rst(rst), .start(mul_start), .a(coef_linear),
    .b(coef_linear), .busy(a2_busy), .product(a2_p)
  );

  rtd_smul #(.AW(32), .BW(32)) u_mul_prod (
    .clk(clk), .rst(rst), .start(prod_start), .a(bmag),
    .b(dmag), .busy(prod_busy), .product(prod_p)
  );

  rtd_sdiv #(.NW(63), .DW(DNM_W), .QW(32)) u_div_rho (
    .clk(clk), .rst(rst), .start(div1_start), .num({num_p, 24'b0}),
    .den(dnm), .busy(div1_busy), .quotient(q1)
  );

  rtd_sdiv #(.NW(46), .DW(34), .QW(14)) u_div_temp (
    .clk(clk), .rst(rst), .start(div2_start), .num(n2),
    .den(d2), .busy(div2_busy), .quotient(q2)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state                <= S_IDLE;
      sample_count         <= RST_SAMPLE_COUNT;
      reference_resistance <= RST_REF_RES;
      zero_resistance      <= RST_ZERO_RES;
      coef_linear          <= RST_COEF_LIN;
      coef_square          <= RST_COEF_SQ;
      sample_sum           <= '0;
      sample_counter       <= '0;
      held_temperature     <= '0;
      alarm_latched        <= 1'b0;
      result_valid         <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SAMPLE_COUNT: sample_count         <= cfg_data[7:0];
          REG_REF_RES:      reference_resistance <= cfg_data[15:0];
          REG_ZERO_RES:     zero_resistance      <= cfg_data[15:0];
          REG_COEF_LIN:     coef_linear          <= cfg_data;
          REG_COEF_SQ:      coef_square          <= cfg_data[31:0];
          default: ;
        endcase
      end

      // drop the result once transferred, unless a new one is loaded now
      if (result_valid && !result_stall && state != S_DONE) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            p_fault  <= fault_status;
            p_upd    <= 1'b0;
            p_raised <= 1'b0;
            if (fault_status == 8'd0) begin
              alarm_latched <= 1'b0;
              if (sample_counter < sample_count) begin
                sample_counter <= sample_counter + 8'd1;
                sample_sum     <= sample_sum + SUM_W'(code);
                state          <= S_DONE;
              end else begin
                // drop this code and convert what is held
                conv_sum       <= sample_sum;
                conv_cnt       <= sample_counter;
                sample_counter <= '0;
                sample_sum     <= '0;
                state          <= (sample_counter != 8'd0) ? S_MUL : S_DONE;
              end
            end else begin
              state <= S_DONE;
              if (!alarm_latched) begin
                alarm_latched    <= 1'b1;
                held_temperature <= '0;
                p_raised         <= 1'b1;
              end
            end
          end
        end
        S_MUL: state <= S_MULW;
        S_MULW: begin
          if (!num_busy && !dnm_busy && !a2_busy) begin
            state <= S_SAT;
          end
        end
        S_SAT: begin
          if (sat1) begin
            rho   <= 33'h1_0000_0000;
            state <= S_RHO;
          end else begin
            state <= S_DIVW;
          end
        end
        S_DIVW: begin
          if (!div1_busy) begin
            rho   <= {1'b0, q1};
            state <= S_RHO;
          end
        end
        S_RHO: begin
          dneg  <= rho > 33'h100_0000;
          dmag  <= (rho > 33'h100_0000) ? 32'(rho - 33'h100_0000)
                                        : 32'(33'h100_0000 - rho);
          state <= S_PROD;
        end
        S_PROD: state <= S_PRODW;
        S_PRODW: begin
          if (!prod_busy) begin
            state <= S_DISC;
          end
        end
        S_DISC: begin
          sq_r   <= '0;
          sq_rem <= '0;
          sq_cnt <= 5'd31;
          if (plus || prod_p == 64'd0) begin
            sq_v  <= 64'(a2) + prod_p;
            state <= S_SQRT;
          end else if (prod_p > 64'(a2)) begin
            // negative discriminant: report top of range
            tres  <= TEMP_MAX;
            state <= S_FIN;
          end else begin
            sq_v  <= 64'(a2) - prod_p;
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          sq_rem <= sq_ge ? 34'(rem_sh - trial) : 34'(rem_sh);
          sq_r   <= {sq_r[30:0], sq_ge};
          sq_v   <= {sq_v[61:0], 2'b00};
          sq_cnt <= sq_cnt - 5'd1;
          if (sq_cnt == 5'd0) begin
            state <= S_DEN;
          end
        end
        S_DEN: begin
          if (den == 33'd0) begin
            tres  <= TEMP_MAX;
            state <= S_FIN;
          end else begin
            // rounded quotient: (dmag*5120 + den) / (2*den)
            n2    <= 46'({dmag, 12'b0}) + 46'({dmag, 10'b0}) + 46'(den);
            d2    <= {den, 1'b0};
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if ({2'b0, n2} >= {d2, 14'b0}) begin
            tres  <= dneg ? TEMP_MAX : TEMP_MIN;
            state <= S_FIN;
          end else begin
            state <= S_DIV2W;
          end
        end
        S_DIV2W: begin
          if (!div2_busy) begin
            if (dneg) begin
              tres <= (q2 > 14'd9000) ? TEMP_MAX : $signed({1'b0, q2});
            end else begin
              tres <= (q2 > 14'd2500) ? TEMP_MIN : -$signed({1'b0, q2});
            end
            state <= S_FIN;
          end
        end
        S_FIN: begin
          held_temperature <= tres;
          p_upd            <= 1'b1;
          state            <= S_DONE;
        end
        S_DONE: begin
          if (!result_valid || !result_stall) begin
            temp_tenths  <= held_temperature;
            temp_updated <= p_upd;
            fault_code   <= p_fault;
            alarm_raised <= p_raised;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
